// ----- rtl/kwsu_pkg.sv -----
// kwsu_pkg: shared codes and struct types of the sorted list union unit
// no dependencies; imported by the cell, the top level and the checker
`default_nettype none

package kwsu_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_PULL   = 2'd2;

  localparam logic [2:0] ST_ACCEPTED    = 3'd0;
  localparam logic [2:0] ST_DELIVERED   = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED   = 3'd2;
  localparam logic [2:0] ST_FULL        = 3'd3;
  localparam logic [2:0] ST_BAD_OPERAND = 3'd4;

  // broadcast commands from the sequencer to every cell
  typedef struct packed {
    logic clear;
    logic append;
    logic advance;
  } cell_ctrl_t;

  // flags of the minimum token that walks down the chain
  typedef struct packed {
    logic valid;
    logic found;
  } tok_flags_t;

endpackage

`default_nettype wire

// ----- rtl/kwsu_ram.sv -----
// kwsu_ram: generic single write, single read RAM with registered read data
// no dependencies
`default_nettype none

module kwsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/kwsu_cell.sv -----
// kwsu_cell: one operand list (RAM, length, read position) and one stage
// of the minimum search chain; uses kwsu_pkg and kwsu_ram
`default_nettype none

module kwsu_cell #(
  parameter int ID_BITS    = 32,
  parameter int LIST_DEPTH = 1024,
  parameter int IW         = 3,
  parameter int CELL_IDX   = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire kwsu_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic                  sel_i,
  input  wire logic                  active_i,
  input  wire logic [ID_BITS-1:0]    record_id_i,
  input  wire kwsu_pkg::tok_flags_t  tok_flags_i,
  input  wire logic [IW-1:0]         tok_idx_i,
  input  wire logic [ID_BITS-1:0]    tok_val_i,
  output kwsu_pkg::tok_flags_t       tok_flags_o,
  output logic      [IW-1:0]         tok_idx_o,
  output logic      [ID_BITS-1:0]    tok_val_o,
  output logic                       full_o
);
  import kwsu_pkg::*;

  localparam int PW = $clog2(LIST_DEPTH + 1);
  localparam int AW = $clog2(LIST_DEPTH);

  logic [PW-1:0]      len_q, len_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [ID_BITS-1:0] head;
  logic               head_valid;
  logic               wr_en;
  logic               take;
  tok_flags_t         tok_flags_d;

  assign full_o     = (len_q == PW'(LIST_DEPTH));
  assign head_valid = (pos_q < len_q);
  assign wr_en      = ctrl_i.append && sel_i && !full_o;

  kwsu_ram #(
    .WIDTH(ID_BITS),
    .DEPTH(LIST_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(len_q[AW-1:0]),
    .wdata_i(record_id_i),
    .raddr_i(pos_q[AW-1:0]),
    .rdata_o(head)
  );

  always_comb begin
    len_d = len_q;
    pos_d = pos_q;
    if (ctrl_i.clear) begin
      len_d = '0;
      pos_d = '0;
    end else begin
      if (wr_en) len_d = len_q + PW'(1);
      if (ctrl_i.advance && sel_i) pos_d = pos_q + PW'(1);
    end
  end

  // strict less keeps the lowest operand on ties
  assign take = tok_flags_i.valid && active_i && head_valid &&
                (!tok_flags_i.found || (head < tok_val_i));

  always_comb begin
    tok_flags_d.valid = tok_flags_i.valid;
    tok_flags_d.found = tok_flags_i.found || take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pos_q       <= '0;
      tok_flags_o <= '0;
    end else begin
      len_q       <= len_d;
      pos_q       <= pos_d;
      tok_flags_o <= tok_flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_idx_o <= take ? IW'(CELL_IDX) : tok_idx_i;
    tok_val_o <= take ? head : tok_val_i;
  end

endmodule

`default_nettype wire

// ----- rtl/kway_sorted_list_union_unit.sv -----
// kway_sorted_list_union_unit: top level, sequencer and chain of list cells
// uses kwsu_pkg, kwsu_cell (which holds kwsu_ram)
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   operation_i, operand_index_i, record_id_i
// out      out  out_valid_o / out_ready_i union_id_o, status_o
// cfg      in   cfg_we_i                  cfg_wdata_i (operands_in_use)
//
// clear, append and unused codes: result registered in the cycle after the input beat.
// pull: states settle (heads read from RAM), inject and wait per head taken, the minimum
// token walking the chain one cell per cycle; each skipped duplicate repeats the search.
// one item at a time; the next beat is taken once the result slot is free.
// reset clears lengths and read positions; list RAM contents need no clear.
`default_nettype none

module kway_sorted_list_union_unit #(
  parameter int MAX_OPERANDS = 8,
  parameter int LIST_DEPTH   = 1024,
  parameter int ID_BITS      = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [2:0]         operand_index_i,
  input  wire logic [ID_BITS-1:0] record_id_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [ID_BITS-1:0] union_id_o,
  output logic      [2:0]         status_o,
  input  wire logic               cfg_we_i,
  input  wire logic [3:0]         cfg_wdata_i
);
  import kwsu_pkg::*;

  localparam int IW  = $clog2(MAX_OPERANDS);
  localparam int CW0 = $clog2(MAX_OPERANDS + 1);
  localparam int CW  = (CW0 > 4) ? CW0 : 4;

  typedef enum logic [1:0] {S_IDLE, S_SETTLE, S_INJECT, S_WAIT} state_e;

  state_e             state_q;
  logic [3:0]         cfg_q;
  logic [ID_BITS-1:0] last_q;
  logic               have_q;

  logic [CW-1:0]      cfg_ext;
  logic [CW-1:0]      eff;
  logic               accept;
  logic               bad_op;
  logic               full_sel;
  logic               dup;
  cell_ctrl_t         ctrl;
  logic [MAX_OPERANDS-1:0] sel;
  logic [MAX_OPERANDS-1:0] full_vec;
  logic [MAX_OPERANDS-1:0] active;

  tok_flags_t         tok_flags [MAX_OPERANDS+1];
  logic [IW-1:0]      tok_idx   [MAX_OPERANDS+1];
  logic [ID_BITS-1:0] tok_val   [MAX_OPERANDS+1];

  tok_flags_t         tok_end;
  logic [IW-1:0]      best_idx;
  logic [ID_BITS-1:0] best_val;

  assign cfg_ext = CW'(cfg_q);
  always_comb begin
    if (cfg_ext == '0)                    eff = CW'(1);
    else if (cfg_ext > CW'(MAX_OPERANDS)) eff = CW'(MAX_OPERANDS);
    else                                  eff = cfg_ext;
  end

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_o || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign bad_op     = !(CW'(operand_index_i) < eff);

  assign tok_end  = tok_flags[MAX_OPERANDS];
  assign best_idx = tok_idx[MAX_OPERANDS];
  assign best_val = tok_val[MAX_OPERANDS];
  assign dup      = have_q && (best_val == last_q);

  always_comb begin
    full_sel = 1'b0;
    for (int k = 0; k < MAX_OPERANDS; k++) begin
      active[k] = (CW'(k) < eff);
      if (state_q == S_WAIT) sel[k] = (best_idx == IW'(k));
      else                   sel[k] = (int'(operand_index_i) == k);
      if (int'(operand_index_i) == k) full_sel = full_vec[k];
    end
  end

  always_comb begin
    ctrl.clear   = accept && (operation_i == OP_CLEAR);
    ctrl.append  = accept && (operation_i == OP_APPEND) && !bad_op && !full_sel;
    ctrl.advance = (state_q == S_WAIT) && tok_end.valid && tok_end.found;
  end

  // token enters the chain empty, cell 0 first
  always_comb begin
    tok_flags[0].valid = (state_q == S_INJECT);
    tok_flags[0].found = 1'b0;
    tok_idx[0]         = '0;
    tok_val[0]         = '0;
  end

  for (genvar g = 0; g < MAX_OPERANDS; g++) begin : g_cell
    kwsu_cell #(
      .ID_BITS   (ID_BITS),
      .LIST_DEPTH(LIST_DEPTH),
      .IW        (IW),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .sel_i      (sel[g]),
      .active_i   (active[g]),
      .record_id_i(record_id_i),
      .tok_flags_i(tok_flags[g]),
      .tok_idx_i  (tok_idx[g]),
      .tok_val_i  (tok_val[g]),
      .tok_flags_o(tok_flags[g+1]),
      .tok_idx_o  (tok_idx[g+1]),
      .tok_val_o  (tok_val[g+1]),
      .full_o     (full_vec[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= 4'd2;
      last_q      <= '0;
      have_q      <= 1'b0;
      out_valid_o <= 1'b0;
      union_id_o  <= '0;
      status_o    <= ST_ACCEPTED;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            union_id_o <= '0;
            priority if (operation_i == OP_PULL) begin
              state_q <= S_SETTLE;
            end else if (operation_i == OP_CLEAR) begin
              last_q      <= '0;
              have_q      <= 1'b0;
              out_valid_o <= 1'b1;
              status_o    <= ST_ACCEPTED;
            end else if (operation_i == OP_APPEND) begin
              out_valid_o <= 1'b1;
              status_o    <= bad_op ? ST_BAD_OPERAND :
                             (full_sel ? ST_FULL : ST_ACCEPTED);
            end else begin
              out_valid_o <= 1'b1;
              status_o    <= ST_ACCEPTED;
            end
          end
        end
        // heads are read from RAM during this cycle
        S_SETTLE: state_q <= S_INJECT;
        S_INJECT: state_q <= S_WAIT;
        S_WAIT: begin
          if (tok_end.valid) begin
            if (!tok_end.found) begin
              state_q     <= S_IDLE;
              out_valid_o <= 1'b1;
              union_id_o  <= '0;
              status_o    <= ST_EXHAUSTED;
            end else if (dup) begin
              state_q <= S_SETTLE;
            end else begin
              state_q     <= S_IDLE;
              last_q      <= best_val;
              have_q      <= 1'b1;
              out_valid_o <= 1'b1;
              union_id_o  <= best_val;
              status_o    <= ST_DELIVERED;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/kwsu_checker.sv -----
// kwsu_checker: port level assertions for kway_sorted_list_union_unit
// uses kwsu_pkg; bound to the top level at the end of this file
`default_nettype none

module kwsu_checker #(
  parameter int ID_BITS = 32
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic [1:0]         operation_i,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [ID_BITS-1:0] union_id_o,
  input wire logic [2:0]         status_o
);
  import kwsu_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(union_id_o) && $stable(status_o))
    else $error("result beat changed while stalled");

  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DELIVERED) |-> union_id_o == '0)
    else $error("union id not zero without delivery");

  a_clear_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == OP_CLEAR)
      |=> out_valid_o && (status_o == ST_ACCEPTED))
    else $error("clear did not answer next cycle");

  a_append_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == OP_APPEND)
      |=> out_valid_o && ((status_o == ST_ACCEPTED) || (status_o == ST_FULL) ||
                          (status_o == ST_BAD_OPERAND)))
    else $error("append answer missing or wrong code");

endmodule

bind kway_sorted_list_union_unit kwsu_checker #(.ID_BITS(ID_BITS)) u_kwsu_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .operation_i(operation_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .union_id_o (union_id_o),
  .status_o   (status_o)
);

`default_nettype wire

// ----- dv/tb_kway_sorted_list_union_unit.sv -----
// tb_kway_sorted_list_union_unit: self-checking bench of the sorted list union unit
// depends on kwsu_pkg and kway_sorted_list_union_unit; predicts every result locally
`timescale 1ns / 1ps

module tb_kway_sorted_list_union_unit;
  import kwsu_pkg::*;

  localparam int NOPS  = 8;
  localparam int DEPTH = 1024;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] id;
    logic [2:0]  st;
  } union_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = OP_CLEAR;
  logic [2:0]  operand_index_i = '0;
  logic [31:0] record_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] union_id_o;
  logic [2:0]  status_o;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_wdata_i = '0;

  always #5 clk_i = ~clk_i;

  kway_sorted_list_union_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .operand_index_i,
    .record_id_i, .out_valid_o, .out_ready_i, .union_id_o, .status_o,
    .cfg_we_i, .cfg_wdata_i
  );

  // predictor state
  logic [31:0] id_mem [NOPS][DEPTH];
  int unsigned list_len [NOPS];
  int unsigned rd_pos [NOPS];
  logic [31:0] last_id;
  bit          emitted;
  logic [3:0]  operands_reg = 4'd2;

  union_result_t pending_results [$];
  int errors = 0;
  int results_seen = 0;
  int delivered_seen = 0;
  int idle_cycles = 0;
  bit rx_hold = 1'b0;
  bit rx_fast = 1'b0;

  function automatic int unsigned active_ops();
    if (operands_reg == 0) return 1;
    if (operands_reg > NOPS) return NOPS;
    return operands_reg;
  endfunction

  function automatic union_result_t predict_union(logic [1:0] op, logic [2:0] idx,
                                                  logic [31:0] rid);
    union_result_t r;
    int unsigned n;
    int unsigned best;
    logic [31:0] best_v;
    bit found;
    bit done;
    r.id = '0;
    r.st = ST_ACCEPTED;
    n = active_ops();
    if (op == OP_CLEAR) begin
      foreach (list_len[k]) begin
        list_len[k] = 0;
        rd_pos[k] = 0;
      end
      last_id = '0;
      emitted = 1'b0;
    end else if (op == OP_APPEND) begin
      if (idx >= n) r.st = ST_BAD_OPERAND;
      else if (list_len[idx] >= DEPTH) r.st = ST_FULL;
      else begin
        id_mem[idx][list_len[idx]] = rid;
        list_len[idx]++;
      end
    end else if (op == OP_PULL) begin
      done = 1'b0;
      while (!done) begin
        found = 1'b0;
        best = 0;
        best_v = '0;
        for (int k = 0; k < n; k++)
          if (rd_pos[k] < list_len[k] && (!found || id_mem[k][rd_pos[k]] < best_v)) begin
            found = 1'b1;
            best = k;
            best_v = id_mem[k][rd_pos[k]];
          end
        if (!found) begin
          r.st = ST_EXHAUSTED;
          done = 1'b1;
        end else begin
          rd_pos[best]++;
          if (!(emitted && best_v == last_id)) begin
            last_id = best_v;
            emitted = 1'b1;
            r.id = best_v;
            r.st = ST_DELIVERED;
            done = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // valid stays up between back to back beats; callers that stop sending drop it
  task automatic send_beat(logic [1:0] op, logic [2:0] idx, logic [31:0] rid,
                           bit no_gap = 1'b0);
    int gap;
    union_result_t exp_r;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    exp_r = predict_union(op, idx, rid);
    pending_results = {pending_results, exp_r};
    in_valid_i <= 1'b1;
    operation_i <= op;
    operand_index_i <= idx;
    record_id_i <= rid;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_wait();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NOPS * 4 + 10) @(posedge clk_i);
  endtask

  task automatic set_operands(logic [3:0] v);
    drain_wait();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    operands_reg = v;
  endtask

  // receiver: random stalls per beat, or a forced hold, or no stalls
  initial begin
    int gap;
    forever begin
      gap = rx_fast ? 0 : $urandom_range(0, 7);
      if (gap != 0 || rx_hold) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        while (rx_hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    union_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result id=%h status=%0d", $time, union_id_o, status_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.st == ST_DELIVERED) delivered_seen++;
        if (union_id_o !== exp_r.id) begin
          $display("%0t: union_id expected %h actual %h", $time, exp_r.id, union_id_o);
          errors++;
        end
        if (status_o !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("tb_kway_sorted_list_union_unit NOT OK");
      $finish;
    end
  end

  task automatic test_directed();
    send_beat(OP_PULL, 0, 0);                 // empty union
    send_beat(OP_APPEND, 0, 32'h0);
    send_beat(OP_APPEND, 0, 32'h5);
    send_beat(OP_APPEND, 1, 32'h5);           // duplicate across lists
    send_beat(OP_APPEND, 1, 32'hFFFF_FFFF);
    send_beat(OP_APPEND, 2, 32'h7);           // bad operand at count 2
    send_beat(OP_APPEND, 7, 32'hAAAA_5555);
    send_beat(2'd3, 3'd5, 32'h5555_AAAA);     // unused code
    repeat (5) send_beat(OP_PULL, 0, 0);
    send_beat(OP_APPEND, 0, 32'h3);           // out of order append
    send_beat(OP_PULL, 0, 0);
    send_beat(OP_CLEAR, 0, 0);
    send_beat(OP_PULL, 0, 0);
    set_operands(4'd0);                       // acts as one
    send_beat(OP_APPEND, 1, 32'h1);
    send_beat(OP_APPEND, 0, 32'h0);
    send_beat(OP_PULL, 0, 0);                 // zero emitted first time
    set_operands(4'd15);                      // acts as eight
    send_beat(OP_APPEND, 7, 32'h9);
    send_beat(OP_PULL, 0, 0);
    send_beat(OP_PULL, 0, 0);
  endtask

  task automatic test_full_list();
    set_operands(4'd1);
    send_beat(OP_CLEAR, 0, 0);
    for (int i = 0; i < DEPTH + 2; i++) send_beat(OP_APPEND, 0, 32'(i), 1'b1);
    send_beat(OP_PULL, 0, 0);
  endtask

  // mostly well-formed merges: fill ascending lists (a random beat now and then), then pull them out
  task automatic test_random_merges(int items);
    int sent;
    int n;
    logic [31:0] base [NOPS];
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(1, 8);
      set_operands(4'((($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : n)));
      send_beat(OP_CLEAR, 0, 0);
      sent++;
      foreach (base[k]) base[k] = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20);
      repeat ($urandom_range(4, 30)) begin
        int idx;
        idx = $urandom_range(0, 7);
        if ($urandom_range(0, 15) == 0)
          send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom);
        else begin
          send_beat(OP_APPEND, 3'(idx), base[idx]);
          if ($urandom_range(0, 2) != 0 && base[idx] < 32'hFFFF_FF00)
            base[idx] += $urandom_range(0, 3);
        end
        sent++;
      end
      repeat ($urandom_range(5, 35)) begin
        send_beat(OP_PULL, 3'($urandom), $urandom);
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      repeat (300) @(posedge clk_i);
      for (int i = 0; i < 12; i++) send_beat(OP_PULL, 0, 0, 1'b1);
    join_any
    rx_hold = 1'b0;
    wait fork;
    rx_fast = 1'b1;
    drain_wait();
    rx_fast = 1'b0;
  endtask

  initial begin
    foreach (list_len[k]) begin
      list_len[k] = 0;
      rd_pos[k] = 0;
    end
    last_id = '0;
    emitted = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random_merges(600);
    test_full_list();
    set_operands(4'd8);
    test_random_merges(60);
    drain_wait();
    $display("covered %0d results (%0d ids delivered) over clears, appends, pulls",
             results_seen, delivered_seen);
    $display("operand counts 0..15, full and bad operand cases, long output stall");
    if (errors == 0)
      $display("tb_kway_sorted_list_union_unit OK");
    else
      $display("tb_kway_sorted_list_union_unit NOT OK");
    $finish;
  end

endmodule

// ----- kway_sorted_list_union_unit.f -----
rtl/kwsu_pkg.sv
rtl/kwsu_ram.sv
rtl/kwsu_cell.sv
rtl/kway_sorted_list_union_unit.sv
rtl/kwsu_checker.sv
dv/tb_kway_sorted_list_union_unit.sv
